// ===== rtl/cnv_pkg.sv =====
// Shared constants for the class name validator.
`default_nettype none

package cnv_pkg;

    // Configuration register indexes
    localparam logic CFG_DESCRIPTOR_MODE = 1'b0;
    localparam logic CFG_SLASH_SEPARATOR = 1'b1;

    // Register reset values
    localparam logic DESCRIPTOR_MODE_RST = 1'b0;
    localparam logic SLASH_SEPARATOR_RST = 1'b1;

    // Array depth limit and the saturation point of the bracket counter
    localparam int unsigned MAX_DIMS     = 255;
    localparam int unsigned BRACKET_SAT  = MAX_DIMS + 1;
    localparam int unsigned BRACKET_W    = $clog2(BRACKET_SAT + 1);

    // Byte codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_OPEN  = 8'h5b; // '['
    localparam logic [7:0] CH_SEMI  = 8'h3b; // ';'
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_J     = 8'h4a;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_Z     = 8'h5a;
    localparam logic [7:0] CH_V     = 8'h56;
    localparam logic [7:0] CH_L     = 8'h4c;

    // Valid ASCII bytes in a name body, indexed by the byte value
    localparam logic [127:0] ASCII_OK = {32'h07fffffe, 32'h87fffffe,
                                         32'h03ff2010, 32'h00000000};

    // Decoded unit limits
    localparam logic [15:0] LATIN1_MAX  = 16'h00a0;
    localparam logic [15:0] TRAIL_LO    = 16'hdc00;
    localparam logic [15:0] TRAIL_HI    = 16'hdfff;
    localparam logic [5:0]  LEAD_SURR   = 6'b110110; // d800..dbff
    localparam logic [5:0]  TRAIL_SURR  = 6'b110111; // dc00..dfff

    // Rejected 8-unit blocks: spaces, line separators and specials
    localparam logic [15:0] BLK_SPACE0  = 16'h2000;
    localparam logic [15:0] BLK_SPACE1  = 16'h2008;
    localparam logic [15:0] BLK_LINESEP = 16'h2028;
    localparam logic [15:0] BLK_SPEC0   = 16'hfff0;
    localparam logic [15:0] BLK_SPEC1   = 16'hfff8;

endpackage

`default_nettype wire

// ===== rtl/class_name_validator_unit.sv =====
// Streaming class name / type descriptor validator, top level.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+----------------------------
//  s_      | in  | s_valid/s_ready  | s_name_byte[7:0]
//  m_      | out | m_valid/m_ready  | m_name_valid
//  cfg_    | in  | cfg_wr_en        | cfg_index, cfg_wdata
//
// One byte per cycle while s_ready is high: the parse state updates in the cycle of the transfer.
// A zero byte loads the result register; its flag shows the next cycle.
// s_ready drops only while a result sits in the output register unaccepted.
// Reset (aresetn low, synchronous) clears the parse state but the partial unit,
// clears the output valid flag and sets the configuration registers to their defaults.
`default_nettype none

module class_name_validator_unit (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_name_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_name_valid,
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_index,
    input  wire logic       cfg_wdata
);

    typedef enum logic [2:0] {
        PH_START,
        PH_BRACKETS,
        PH_BODY_NAME,
        PH_BODY_DESC,
        PH_END
    } phase_t;

    localparam int unsigned CW = cnv_pkg::BRACKET_W;

    phase_t          phase_reg, phase_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            ce_reg, ce_next;       // current component still empty
    logic [1:0]      pend_reg, pend_next;   // continuation bytes still due
    logic [15:0]     part_reg, part_next;
    logic            trail_reg, trail_next; // low surrogate must follow
    logic            failed_reg, failed_next;
    logic            desc_mode_reg, desc_mode_next;
    logic            slash_reg, slash_next;
    logic            m_valid_reg, m_valid_next;
    logic            m_name_valid_reg, m_name_valid_next;

    logic            accept;
    logic            name_done;
    logic            name_ok;
    logic            do_body;
    logic            do_check;
    logic [15:0]     unit;
    logic [12:0]     blk;
    logic [7:0]      sep;
    logic [7:0]      b;

    assign b         = s_name_byte;
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign name_done = accept && (b == cnv_pkg::CH_NUL);
    assign sep       = slash_reg ? cnv_pkg::CH_SLASH : cnv_pkg::CH_DOT;
    assign blk       = unit[15:3];

    assign name_ok = !failed_reg && (pend_reg == 2'd0) && !trail_reg &&
                     ((phase_reg == PH_END) ||
                      ((phase_reg == PH_BODY_NAME) && !ce_reg));

    always_comb begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        ce_next     = ce_reg;
        pend_next   = pend_reg;
        part_next   = part_reg;
        trail_next  = trail_reg;
        failed_next = failed_reg;
        do_body     = 1'b0;
        do_check    = 1'b0;
        unit        = 16'h0000;

        if (accept) begin
            if (name_done) begin
                phase_next  = PH_START;
                cnt_next    = '0;
                ce_next     = 1'b1;
                pend_next   = 2'd0;
                part_next   = 16'h0000;
                trail_next  = 1'b0;
                failed_next = 1'b0;
            end else if (!failed_reg) begin
                case (phase_reg)
                    PH_START, PH_BRACKETS: begin
                        if (b == cnv_pkg::CH_OPEN) begin
                            if (cnt_reg < CW'(cnv_pkg::BRACKET_SAT)) begin
                                cnt_next = cnt_reg + CW'(1);
                            end
                            phase_next = PH_BRACKETS;
                            if (cnt_next > CW'(cnv_pkg::MAX_DIMS)) begin
                                failed_next = 1'b1;
                            end
                        end else if (phase_reg == PH_BRACKETS || desc_mode_reg) begin
                            case (b)
                                cnv_pkg::CH_B, cnv_pkg::CH_C, cnv_pkg::CH_D,
                                cnv_pkg::CH_F, cnv_pkg::CH_I, cnv_pkg::CH_J,
                                cnv_pkg::CH_S, cnv_pkg::CH_Z: begin
                                    phase_next = PH_END;
                                end
                                cnv_pkg::CH_V: begin
                                    // void only as a bare type
                                    if (cnt_reg == '0) begin
                                        phase_next = PH_END;
                                    end else begin
                                        failed_next = 1'b1;
                                    end
                                end
                                cnv_pkg::CH_L: begin
                                    phase_next = PH_BODY_DESC;
                                    ce_next    = 1'b1;
                                end
                                default: begin
                                    failed_next = 1'b1;
                                end
                            endcase
                        end else begin
                            phase_next = PH_BODY_NAME;
                            ce_next    = 1'b1;
                            do_body    = 1'b1;
                        end
                    end
                    PH_BODY_NAME, PH_BODY_DESC: begin
                        do_body = 1'b1;
                    end
                    default: begin
                        // anything after the end of the type
                        failed_next = 1'b1;
                    end
                endcase
            end
        end

        if (do_body) begin
            if (pend_reg != 2'd0) begin
                part_next = {part_reg[9:0], b[5:0]};
                pend_next = pend_reg - 2'd1;
                if (pend_reg == 2'd1) begin
                    do_check = 1'b1;
                    unit     = part_next;
                end
            end else if (b[7]) begin
                if (!b[5]) begin
                    part_next = {11'h000, b[4:0]};
                    pend_next = 2'd1;
                end else begin
                    part_next = {12'h000, b[3:0]};
                    pend_next = 2'd2;
                end
            end else if (trail_reg) begin
                do_check = 1'b1;
                unit     = {8'h00, b};
            end else if (b == cnv_pkg::CH_SEMI) begin
                if (phase_reg == PH_BODY_DESC && !ce_next) begin
                    phase_next = PH_END;
                end else begin
                    failed_next = 1'b1;
                end
            end else if (b == cnv_pkg::CH_SLASH || b == cnv_pkg::CH_DOT) begin
                if (b != sep || ce_next) begin
                    failed_next = 1'b1;
                end else begin
                    ce_next = 1'b1;
                end
            end else if (cnv_pkg::ASCII_OK[b[6:0]]) begin
                ce_next = 1'b0;
            end else begin
                failed_next = 1'b1;
            end
        end

        if (do_check) begin
            if (trail_reg) begin
                trail_next = 1'b0;
                if (unit >= cnv_pkg::TRAIL_LO && unit <= cnv_pkg::TRAIL_HI) begin
                    ce_next = 1'b0;
                end else begin
                    failed_next = 1'b1;
                end
            end else if (unit[15:8] == 8'h00) begin
                if (unit > cnv_pkg::LATIN1_MAX) begin
                    ce_next = 1'b0;
                end else begin
                    failed_next = 1'b1;
                end
            end else if (unit[15:10] == cnv_pkg::LEAD_SURR) begin
                trail_next = 1'b1;
            end else if (unit[15:10] == cnv_pkg::TRAIL_SURR) begin
                failed_next = 1'b1;
            end else if (blk == cnv_pkg::BLK_SPACE0[15:3] ||
                         blk == cnv_pkg::BLK_SPACE1[15:3] ||
                         blk == cnv_pkg::BLK_LINESEP[15:3] ||
                         blk == cnv_pkg::BLK_SPEC0[15:3] ||
                         blk == cnv_pkg::BLK_SPEC1[15:3]) begin
                failed_next = 1'b1;
            end else begin
                ce_next = 1'b0;
            end
        end
    end

    always_comb begin
        desc_mode_next = desc_mode_reg;
        slash_next     = slash_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                cnv_pkg::CFG_DESCRIPTOR_MODE: desc_mode_next = cfg_wdata;
                cnv_pkg::CFG_SLASH_SEPARATOR: slash_next     = cfg_wdata;
                default: begin
                    desc_mode_next = desc_mode_reg;
                end
            endcase
        end
    end

    always_comb begin
        m_valid_next      = m_valid_reg;
        m_name_valid_next = m_name_valid_reg;
        if (name_done) begin
            m_valid_next      = 1'b1;
            m_name_valid_next = name_ok;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_START;
            cnt_reg       <= '0;
            ce_reg        <= 1'b1;
            pend_reg      <= 2'd0;
            trail_reg     <= 1'b0;
            failed_reg    <= 1'b0;
            desc_mode_reg <= cnv_pkg::DESCRIPTOR_MODE_RST;
            slash_reg     <= cnv_pkg::SLASH_SEPARATOR_RST;
            m_valid_reg   <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            ce_reg        <= ce_next;
            pend_reg      <= pend_next;
            trail_reg     <= trail_next;
            failed_reg    <= failed_next;
            desc_mode_reg <= desc_mode_next;
            slash_reg     <= slash_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        part_reg         <= part_next;
        m_name_valid_reg <= m_name_valid_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_name_valid = m_name_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/cnv_checker.sv =====
// Port-level assertions for the class name validator, bound to the top level.
`default_nettype none

module cnv_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic [7:0] s_name_byte,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_name_valid
);

    // input stalls only behind an untaken result
    a_ready_only_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("s_ready low without a blocked result");

    // terminator transfer yields a result next cycle
    a_nul_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_name_byte == cnv_pkg::CH_NUL) |=> m_valid)
        else $error("no result after terminator");

    // other bytes never produce a result
    a_byte_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_name_byte != cnv_pkg::CH_NUL) |=> !m_valid)
        else $error("result without terminator");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_name_valid)))
        else $error("stalled result changed");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind class_name_validator_unit cnv_checker u_cnv_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_name_byte  (s_name_byte),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_name_valid (m_name_valid)
);

`default_nettype wire

// ===== tb/sv/tb_class_name_validator_unit.sv =====
// Self-checking testbench for the streaming class name / descriptor validator.
`timescale 1ns / 1ps

module tb_class_name_validator_unit;

    localparam int unsigned QUIET_LIMIT = 2000;
    localparam logic [127:0] BODY_CHAR_OK = {32'h07fffffe, 32'h87fffffe,
                                             32'h03ff2010, 32'h00000000};

    typedef enum logic [2:0] {
        SCAN_START,
        SCAN_DIMS,
        SCAN_CLASS,
        SCAN_REF,
        SCAN_DONE
    } scan_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_name_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_name_valid;
    logic       cfg_wr_en = 1'b0;
    logic       cfg_index = 1'b0;
    logic       cfg_wdata = 1'b0;

    class_name_validator_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_name_byte (s_name_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_name_valid(m_name_valid),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Shadow registers and parser state of the predictor
    logic        shadow_desc_mode = cnv_pkg::DESCRIPTOR_MODE_RST;
    logic        shadow_slash = cnv_pkg::SLASH_SEPARATOR_RST;
    logic [8:0]  p_dims;
    scan_t       p_phase;
    logic        p_comp_empty;
    logic [1:0]  p_pending;
    logic [15:0] p_unit;
    logic        p_need_trail;
    logic        p_bad;

    logic        verdict_q[$];
    logic [7:0]  name_buf[$];
    string       name_chars = "abcxyzABCXYZ0189$_-";
    string       prim_chars = "BCDFIJSZV";

    logic        steady = 1'b0;
    logic        want_bit;
    int unsigned mismatches = 0;
    int unsigned bytes_sent = 0;
    int unsigned names_sent = 0;
    int unsigned valid_seen = 0;
    int unsigned quiet = 0;

    function void clear_scan();
        p_dims       = '0;
        p_phase      = SCAN_START;
        p_comp_empty = 1'b1;
        p_pending    = '0;
        p_unit       = '0;
        p_need_trail = 1'b0;
        p_bad        = 1'b0;
    endfunction

    function void judge_unit(input logic [15:0] u);
        logic [15:0] blk;
        blk = u & 16'hfff8;
        if (p_need_trail) begin
            p_need_trail = 1'b0;
            if (u >= 16'hdc00 && u <= 16'hdfff) p_comp_empty = 1'b0;
            else p_bad = 1'b1;
        end else if (u[15:8] == 8'h00) begin
            if (u > 16'h00a0) p_comp_empty = 1'b0;
            else p_bad = 1'b1;
        end else if (u[15:10] == 6'b110110) begin
            p_need_trail = 1'b1;
        end else if (u[15:10] == 6'b110111) begin
            p_bad = 1'b1;
        end else if (blk == 16'h2000 || blk == 16'h2008 || blk == 16'h2028 ||
                     blk == 16'hfff0 || blk == 16'hfff8) begin
            p_bad = 1'b1;
        end else begin
            p_comp_empty = 1'b0;
        end
    endfunction

    function void eat_body_byte(input logic [7:0] b);
        logic [7:0] sep;
        sep = shadow_slash ? cnv_pkg::CH_SLASH : cnv_pkg::CH_DOT;
        if (p_pending != 2'd0) begin
            p_unit    = {p_unit[9:0], b[5:0]};
            p_pending = p_pending - 2'd1;
            if (p_pending == 2'd0) judge_unit(p_unit);
        end else if (b[7]) begin
            if (!b[5]) begin
                p_unit    = {11'd0, b[4:0]};
                p_pending = 2'd1;
            end else begin
                p_unit    = {12'd0, b[3:0]};
                p_pending = 2'd2;
            end
        end else if (p_need_trail) begin
            judge_unit({8'h00, b});
        end else if (b == cnv_pkg::CH_SEMI) begin
            if (p_phase == SCAN_REF && !p_comp_empty) p_phase = SCAN_DONE;
            else p_bad = 1'b1;
        end else if (b == cnv_pkg::CH_SLASH || b == cnv_pkg::CH_DOT) begin
            if (b != sep || p_comp_empty) p_bad = 1'b1;
            else p_comp_empty = 1'b1;
        end else if (BODY_CHAR_OK[b[6:0]]) begin
            p_comp_empty = 1'b0;
        end else begin
            p_bad = 1'b1;
        end
    endfunction

    function void eat_type_char(input logic [7:0] b);
        case (b)
            cnv_pkg::CH_B, cnv_pkg::CH_C, cnv_pkg::CH_D, cnv_pkg::CH_F,
            cnv_pkg::CH_I, cnv_pkg::CH_J, cnv_pkg::CH_S, cnv_pkg::CH_Z: begin
                p_phase = SCAN_DONE;
            end
            cnv_pkg::CH_V: begin
                if (p_dims == 9'd0) p_phase = SCAN_DONE;
                else p_bad = 1'b1;
            end
            cnv_pkg::CH_L: begin
                p_phase      = SCAN_REF;
                p_comp_empty = 1'b1;
            end
            default: p_bad = 1'b1;
        endcase
    endfunction

    // Advance the predictor by one accepted byte; a zero byte yields a verdict
    function void predict_byte(input logic [7:0] b);
        logic ok;
        if (b == cnv_pkg::CH_NUL) begin
            ok = !p_bad && p_pending == 2'd0 && !p_need_trail &&
                 (p_phase == SCAN_DONE ||
                  (p_phase == SCAN_CLASS && !p_comp_empty));
            verdict_q.insert(verdict_q.size(), ok);
            clear_scan();
        end else if (!p_bad) begin
            case (p_phase)
                SCAN_START, SCAN_DIMS: begin
                    if (b == cnv_pkg::CH_OPEN) begin
                        if (p_dims < 9'd256) p_dims = p_dims + 9'd1;
                        p_phase = SCAN_DIMS;
                        if (p_dims > 9'd255) p_bad = 1'b1;
                    end else if (p_phase == SCAN_DIMS || shadow_desc_mode) begin
                        eat_type_char(b);
                    end else begin
                        p_phase      = SCAN_CLASS;
                        p_comp_empty = 1'b1;
                        eat_body_byte(b);
                    end
                end
                SCAN_CLASS, SCAN_REF: eat_body_byte(b);
                default: p_bad = 1'b1;
            endcase
        end
    endfunction

    // Name building
    function void add_byte(input logic [7:0] v);
        name_buf.insert(name_buf.size(), v);
    endfunction

    function void push_str(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endfunction

    function void push_unit(input logic [15:0] u);
        if (u < 16'h0800) begin
            add_byte({3'b110, u[10:6]});
        end else begin
            add_byte({4'b1110, u[15:12]});
            add_byte({2'b10, u[11:6]});
        end
        add_byte({2'b10, u[5:0]});
    endfunction

    function void push_rand_unit();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
            add_byte(name_chars[$urandom_range(name_chars.len() - 1)]);
        end else if (pick < 80) begin
            push_unit(16'($urandom_range(16'h07ff, 16'h0080)));
        end else if (pick < 92) begin
            push_unit(16'($urandom_range(16'hffff, 16'h0800)));
        end else begin
            push_unit(16'($urandom_range(16'hdbff, 16'hd800)));
            push_unit(16'($urandom_range(16'hdfff, 16'hdc00)));
        end
    endfunction

    function void gen_body(input logic [7:0] sep);
        int ncomp;
        ncomp = $urandom_range(3, 1);
        for (int c = 0; c < ncomp; c++) begin
            if (c != 0) add_byte(sep);
            repeat ($urandom_range(4, 1)) push_rand_unit();
        end
    endfunction

    function void gen_descriptor(input logic [7:0] sep);
        if ($urandom_range(99) >= 60) begin
            repeat ($urandom_range(3, 1)) add_byte(cnv_pkg::CH_OPEN);
        end
        if ($urandom_range(9) < 6) begin
            add_byte(cnv_pkg::CH_L);
            gen_body(sep);
            add_byte(cnv_pkg::CH_SEMI);
        end else begin
            add_byte(prim_chars[$urandom_range(prim_chars.len() - 1)]);
        end
    endfunction

    function logic [7:0] noise_byte();
        case ($urandom_range(7))
            0: return cnv_pkg::CH_OPEN;
            1: return cnv_pkg::CH_SEMI;
            2: return cnv_pkg::CH_SLASH;
            3: return cnv_pkg::CH_DOT;
            4: return cnv_pkg::CH_L;
            default: return 8'($urandom_range(255, 1));
        endcase
    endfunction

    function void build_random_name();
        int kind;
        int pos;
        logic [7:0] sep;
        sep = shadow_slash ? cnv_pkg::CH_SLASH : cnv_pkg::CH_DOT;
        name_buf.delete();
        kind = $urandom_range(99);
        if (kind < 80) begin
            if (kind % 2) gen_body(sep);
            else gen_descriptor(sep);
            // a share of well-formed names gets one byte broken
            if (kind >= 55) begin
                pos = $urandom_range(name_buf.size() - 1);
                case ($urandom_range(2))
                    0: name_buf[pos] = noise_byte();
                    1: name_buf.insert(pos, noise_byte());
                    default: void'(name_buf.pop_back());
                endcase
            end
        end else begin
            repeat ($urandom_range(8, 1)) add_byte(noise_byte());
        end
    endfunction

    // Drive one byte and wait for its transfer
    task send_byte(input logic [7:0] b);
        while (!steady && $urandom_range(99) < 9) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_name_byte <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
        predict_byte(b);
    endtask

    task send_name();
        foreach (name_buf[i]) send_byte(name_buf[i]);
        send_byte(cnv_pkg::CH_NUL);
        names_sent++;
        name_buf.delete();
    endtask

    task settle();
        s_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task write_reg(input logic idx, input logic val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            cnv_pkg::CFG_DESCRIPTOR_MODE: shadow_desc_mode = val;
            cnv_pkg::CFG_SLASH_SEPARATOR: shadow_slash = val;
            default: ;
        endcase
    endtask

    task apply_setting(input logic desc, input logic slash);
        settle();
        write_reg(cnv_pkg::CFG_DESCRIPTOR_MODE, desc);
        write_reg(cnv_pkg::CFG_SLASH_SEPARATOR, slash);
        cfg_wr_en <= 1'b0;
    endtask

    task test_plain_names();
        push_str("");            send_name();
        push_str("pkg/Cls_1$-"); send_name();
        push_str("a//b");        send_name();
        push_str("a.b");         send_name();
        push_str("/a");          send_name();
        push_str("a/");          send_name();
        push_str("a;");          send_name();
        push_str("a"); add_byte(8'h7f); send_name();
    endtask

    task test_multibyte_units();
        push_unit(16'h00a0); send_name();
        push_unit(16'h00a1); send_name();
        push_str("x"); push_unit(16'hd800); push_unit(16'hdc00); send_name();
        push_str("x"); push_unit(16'hd800); push_str(";"); send_name();
        push_unit(16'hdc00); send_name();
        push_str("x"); add_byte(8'hc2); send_name();
        push_str("x"); push_unit(16'hd800); send_name();
        push_unit(16'h2000); send_name();
        push_unit(16'h2028); send_name();
        push_unit(16'h2030); send_name();
        add_byte(8'hff); add_byte(8'hbf); add_byte(8'hbf);
        send_name();
    endtask

    task test_descriptors();
        apply_setting(1'b1, 1'b1);
        push_str("I");     send_name();
        push_str("V");     send_name();
        push_str("[V");    send_name();
        push_str("[[J");   send_name();
        push_str("LA;");   send_name();
        push_str("L;");    send_name();
        push_str("LA;x");  send_name();
        push_str("Q");     send_name();
        push_str("[");     send_name();
        push_str("La/b;"); send_name();
        // deepest legal array, then one bracket too many
        repeat (255) add_byte(cnv_pkg::CH_OPEN);
        push_str("I"); send_name();
        repeat (256) add_byte(cnv_pkg::CH_OPEN);
        push_str("I"); send_name();
    endtask

    task test_dot_separator();
        apply_setting(1'b0, 1'b0);
        push_str("a.b"); send_name();
        push_str("a/b"); send_name();
        push_str("[I");  send_name();
        apply_setting(1'b1, 1'b0);
        push_str("La.b;"); send_name();
    endtask

    task test_random_mix();
        int unsigned target;
        for (int ph = 0; ph < 4; ph++) begin
            apply_setting(ph[0], !ph[1]);
            steady = (ph == 2);
            target = bytes_sent + 60;
            while (bytes_sent < target) begin
                build_random_name();
                send_name();
            end
        end
        steady = 1'b0;
    endtask

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 9);
    end

    // Verdict checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected verdict, expected none, got %0b",
                         $time, m_name_valid);
                mismatches++;
            end else begin
                want_bit = verdict_q.pop_front();
                if (want_bit) valid_seen++;
                if (m_name_valid !== want_bit) begin
                    $display("%0t: name_valid mismatch, expected %0b, got %0b",
                             $time, want_bit, m_name_valid);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: cycles without any transfer or register write
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) quiet = 0;
        else quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet);
            $display("class_name_validator_unit verification failed");
            $finish;
        end
    end

    initial begin
        clear_scan();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_plain_names();
        test_multibyte_units();
        test_descriptors();
        test_dot_separator();
        test_random_mix();
        settle();
        repeat (10) @(posedge aclk);
        $display("Checked %0d names (%0d bytes), %0d of them valid,", names_sent, bytes_sent,
                 valid_seen);
        $display("over all mode/separator settings with random stalls on both sides.");
        if (mismatches == 0) begin
            $display("class_name_validator_unit verification clean");
        end else begin
            $display("class_name_validator_unit verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/cnv_pkg.sv
rtl/class_name_validator_unit.sv
rtl/cnv_checker.sv
tb/sv/tb_class_name_validator_unit.sv
